### rtl/hasd_pkg.sv
// ----------------------------------------------------------------------------
// hasd_pkg
// Types and constants shared by the hex-text SHA-1 digest core.
// ----------------------------------------------------------------------------
package hasd_pkg;

    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [7:0] PAD_ZERO  = 8'h00;
    localparam logic [5:0] LEN_START = 6'd56;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_INIT  = 4'd1,  // reset hash and counters
        CMD_CHAR  = 4'd2,  // write one character into the block
        CMD_PAD   = 4'd3,  // write one padding byte
        CMD_LEN   = 4'd4,  // write one length byte
        CMD_START = 4'd5,  // load working vars from hash
        CMD_ROUND = 4'd6,  // one SHA-1 round
        CMD_FOLD  = 4'd7,  // add working vars into hash
        CMD_SNAP  = 4'd8   // restart the length byte count
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] pad_byte;
        logic       char_lo;  // 1 = low nibble character
    } t_ctrl;

    typedef struct packed {
        logic [5:0] fill;
        logic [6:0] round;
    } t_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

### rtl/hasd_if.sv
// ----------------------------------------------------------------------------
// hasd_in_if / hasd_out_if
// Valid/ready channels for input bytes and digest words.
// ----------------------------------------------------------------------------
interface hasd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
    modport source (output valid, data_byte, has_byte, is_last, input ready);
    modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface hasd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/hasd_datapath.sv
// ----------------------------------------------------------------------------
// hasd_datapath
// Block buffer, message schedule window, round unit and hash state.
// ----------------------------------------------------------------------------
module hasd_datapath
    import hasd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic [7:0]  i_byte,
    input  logic [2:0]  i_word_sel,
    output t_stat       o_stat,
    output logic [31:0] o_word
);

    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [6:0]  r_round;
    logic [63:0] r_len;
    logic [2:0]  r_len_idx;

    logic [7:0]  w_in_byte;
    logic [31:0] w_wt, w_f, w_k, w_t, w_wnext;

    // length stays put from the last character until the hash restarts
    always_comb begin
        case (i_ctrl.cmd)
            CMD_CHAR: w_in_byte = hex_char(i_ctrl.char_lo ? i_byte[3:0] : i_byte[7:4]);
            CMD_LEN:  w_in_byte = r_len[63 - 8*r_len_idx -: 8];
            default:  w_in_byte = i_ctrl.pad_byte;
        endcase
    end

    // Rounds 0..15 use the loaded words; later words expand in the window
    assign w_wnext = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                   | {31'd0, (r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31])};
    assign w_wt = (r_round < 7'd16) ? r_w[0] : w_wnext;

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d); w_k = 32'h5A827999;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;            w_k = 32'h6ED9EBA1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); w_k = 32'h8F1BBCDC;
        end else begin
            w_f = r_b ^ r_c ^ r_d;            w_k = 32'hCA62C1D6;
        end
    end
    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_wt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= SHA_H0; r_h[1] <= SHA_H1; r_h[2] <= SHA_H2;
            r_h[3] <= SHA_H3; r_h[4] <= SHA_H4;
            r_fill <= '0; r_len <= '0; r_round <= '0; r_len_idx <= '0;
        end else begin
            case (i_ctrl.cmd)
                CMD_INIT: begin
                    r_h[0] <= SHA_H0; r_h[1] <= SHA_H1; r_h[2] <= SHA_H2;
                    r_h[3] <= SHA_H3; r_h[4] <= SHA_H4;
                    r_fill <= '0; r_len <= '0;
                end
                CMD_CHAR, CMD_PAD, CMD_LEN: begin
                    // shift the byte into the word window, word 15 low byte
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
                    end
                    r_w[15] <= {r_w[15][23:0], w_in_byte};
                    r_fill  <= r_fill + 6'd1;
                    if (i_ctrl.cmd == CMD_CHAR) r_len <= r_len + 64'd8;
                    if (i_ctrl.cmd == CMD_LEN)  r_len_idx <= r_len_idx + 3'd1;
                end
                CMD_SNAP: begin
                    r_len_idx <= '0;
                end
                CMD_START: begin
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_round <= '0;
                end
                CMD_ROUND: begin
                    r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a; r_a <= w_t;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wt;
                    r_round <= r_round + 7'd1;
                end
                CMD_FOLD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.fill  = r_fill;
    assign o_stat.round = r_round;
    assign o_word = (i_word_sel < 3'd5) ? swap_bytes(r_h[i_word_sel]) : '0;

endmodule

### rtl/hasd_ctrl.sv
// ----------------------------------------------------------------------------
// hasd_ctrl
// Sequencer: characters, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module hasd_ctrl
    import hasd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_has_byte,
    input  logic       i_is_last,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_word_sel,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HI    = 9'b000000010,
        S_LO    = 9'b000000100,
        S_PAD   = 9'b000001000,
        S_LEN   = 9'b000010000,
        S_START = 9'b000100000,
        S_ROUND = 9'b001000000,
        S_FOLD  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;       // where to go after a compression
    logic   r_last, n_last;
    logic   r_mark, n_mark;     // 0x80 still to be written
    logic [2:0] r_sel, n_sel;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_word_sel  = r_sel;

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_last = r_last;
        n_mark = r_mark; n_sel = r_sel;
        o_ctrl = '{cmd: CMD_NONE, pad_byte: PAD_ZERO, char_lo: 1'b0};
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_last = i_is_last;
                n_mark = 1'b1;
                if (i_has_byte) n_state = S_HI;
                else if (i_is_last) begin
                    o_ctrl.cmd = CMD_SNAP; n_state = S_PAD;
                end
            end
            S_HI: begin
                o_ctrl.cmd = CMD_CHAR;
                n_state = S_LO;
            end
            S_LO: begin
                o_ctrl.cmd = CMD_CHAR; o_ctrl.char_lo = 1'b1;
                // block completes when fill wraps from 63
                if (i_stat.fill == 6'd63) begin
                    n_state = S_START;
                    n_ret = r_last ? S_PAD : S_IDLE;
                end else n_state = r_last ? S_PAD : S_IDLE;
                if (r_last && !(i_stat.fill == 6'd63)) n_state = S_PAD;
            end
            S_PAD: begin
                if (i_stat.fill == LEN_START && !r_mark) begin
                    n_state = S_LEN;
                end else begin
                    o_ctrl.cmd = CMD_PAD;
                    o_ctrl.pad_byte = r_mark ? PAD_MARK : PAD_ZERO;
                    n_mark = 1'b0;
                    if (i_stat.fill == 6'd63) begin
                        n_state = S_START; n_ret = S_PAD;
                    end
                end
            end
            S_LEN: begin
                o_ctrl.cmd = CMD_LEN;
                if (i_stat.fill == 6'd63) begin
                    n_state = S_START; n_ret = S_OUT; n_sel = '0;
                end
            end
            S_START: begin
                o_ctrl.cmd = CMD_START; n_state = S_ROUND;
            end
            S_ROUND: begin
                o_ctrl.cmd = CMD_ROUND;
                if (i_stat.round == 7'd79) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_ctrl.cmd = CMD_FOLD; n_state = r_ret;
            end
            S_OUT: if (i_out_ready) begin
                if (r_sel == 3'd4) begin
                    o_ctrl.cmd = CMD_INIT; n_state = S_IDLE;
                end else n_sel = r_sel + 3'd1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer state registers; synchronous active-low reset returns to idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= S_IDLE; r_last <= 1'b0;
            r_mark <= 1'b0; r_sel <= '0;
        end else begin
            r_state <= n_state; r_ret <= n_ret; r_last <= n_last;
            r_mark <= n_mark; r_sel <= n_sel;
        end
    end

endmodule

### rtl/hex_ascii_sha1_digest_core.sv
// ----------------------------------------------------------------------------
// hex_ascii_sha1_digest_core
// SHA-1 of the upper-case hex text of a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one beat per region byte (has_byte = 1) or a
//   finish-only beat (has_byte = 0). Each byte becomes two hex characters.
//   A beat with is_last = 1 closes the message; the output channel then
//   sends five beats, digest words H0..H4, each byte-swapped, word_index 0..4,
//   last_word on the fifth. The hash then restarts from its initial values.
//   Every 64th character adds a compression on the shared round unit (one
//   round a cycle). A last beat adds padding (one byte a cycle outside
//   compressions), one or two compressions and the five output beats. Input
//   is taken only when idle, so not while characters, padding, a compression
//   or the digest output run; a stalled receiver holds the current word.
//   Reset (synchronous, active low) loads the initial hash and clears count.
// ----------------------------------------------------------------------------
module hex_ascii_sha1_digest_core
    import hasd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hasd_in_if.sink    i_in,
    hasd_out_if.source o_out
);

    t_ctrl      w_ctrl;
    t_stat      w_stat;
    logic [2:0] w_sel;
    logic [31:0] w_word;
    logic [7:0] r_byte;
    logic       w_acc;

    assign w_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_acc) r_byte <= i_in.data_byte;
    end

    hasd_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_in.valid),
        .i_has_byte (i_in.has_byte),
        .i_is_last  (i_in.is_last),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_word_sel (w_sel),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    hasd_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_ctrl    (w_ctrl),
        .i_byte    (r_byte),
        .i_word_sel(w_sel),
        .o_stat    (w_stat),
        .o_word    (w_word)
    );

    assign o_out.digest_word = w_word;
    assign o_out.word_index  = w_sel;
    assign o_out.last_word   = (w_sel == 3'd4);

    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.word_index <= 3'd4) else $error("word index");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("in/out overlap");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_word)
        |=> o_out.word_index == $past(o_out.word_index) + 3'd1)
        else $error("index step");

endmodule
